[hw/rtl/rvdec_pkg.sv]
// ----------------------------------------------------------------------------
// rvdec_pkg
// Shared types and encodings for the RV64I instruction decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package rvdec_pkg;

    localparam int unsigned WORD_W  = 32;
    localparam int unsigned KIND_W  = 6;
    localparam int unsigned REG_W   = 5;
    localparam int unsigned SPOS_W  = 5;
    localparam int unsigned SHAMT_W = 6;

    localparam logic [6:0] OPC_LUI       = 7'b0110111;
    localparam logic [6:0] OPC_AUIPC     = 7'b0010111;
    localparam logic [6:0] OPC_JAL       = 7'b1101111;
    localparam logic [6:0] OPC_JALR      = 7'b1100111;
    localparam logic [6:0] OPC_BRANCH    = 7'b1100011;
    localparam logic [6:0] OPC_LOAD      = 7'b0000011;
    localparam logic [6:0] OPC_STORE     = 7'b0100011;
    localparam logic [6:0] OPC_OP_IMM    = 7'b0010011;
    localparam logic [6:0] OPC_OP        = 7'b0110011;
    localparam logic [6:0] OPC_MISC_MEM  = 7'b0001111;
    localparam logic [6:0] OPC_SYSTEM    = 7'b1110011;
    localparam logic [6:0] OPC_OP_IMM_32 = 7'b0011011;
    localparam logic [6:0] OPC_OP_32     = 7'b0111011;

    localparam logic [6:0] F7_ZERO = 7'b0000000;
    localparam logic [6:0] F7_ALT  = 7'b0100000;
    localparam logic [5:0] F6_ZERO = 6'b000000;
    localparam logic [5:0] F6_ALT  = 6'b010000;

    localparam logic [2:0] F3_ADD = 3'd0;
    localparam logic [2:0] F3_SLL = 3'd1;
    localparam logic [2:0] F3_SR  = 3'd5;

    localparam logic [11:0] F12_ECALL  = 12'd0;
    localparam logic [11:0] F12_EBREAK = 12'd1;

    localparam logic [SPOS_W-1:0] SPOS_NONE = 5'd0;
    localparam logic [SPOS_W-1:0] SPOS_I    = 5'd11;
    localparam logic [SPOS_W-1:0] SPOS_B    = 5'd12;
    localparam logic [SPOS_W-1:0] SPOS_J    = 5'd20;
    localparam logic [SPOS_W-1:0] SPOS_U    = 5'd31;

    typedef enum logic [KIND_W-1:0] {
        K_LUI, K_AUIPC, K_JAL, K_JALR,
        K_BEQ, K_BNE, K_BLT, K_BGE, K_BLTU, K_BGEU,
        K_LB, K_LH, K_LW, K_LD, K_LBU, K_LHU, K_LWU,
        K_SB, K_SH, K_SW, K_SD,
        K_ADDI, K_SLLI, K_SLTI, K_SLTIU, K_XORI, K_SRLI, K_SRAI, K_ORI, K_ANDI,
        K_ADD, K_SLL, K_SLT, K_SLTU, K_XOR, K_SRL, K_OR, K_AND, K_SUB, K_SRA,
        K_FENCE, K_ECALL, K_EBREAK,
        K_ADDIW, K_SLLIW, K_SRLIW, K_SRAIW,
        K_ADDW, K_SUBW, K_SLLW, K_SRLW, K_SRAW
    } kind_t;

    typedef struct packed {
        logic               valid;
        kind_t              kind;
        logic [REG_W-1:0]   rd;
        logic [REG_W-1:0]   rs1;
        logic [REG_W-1:0]   rs2;
        logic [WORD_W-1:0]  imm;
        logic [SPOS_W-1:0]  spos;
        logic [SHAMT_W-1:0] shamt;
    } dec_res_t;

endpackage

`default_nettype wire

[hw/rtl/rvdec_decode.sv]
// ----------------------------------------------------------------------------
// rvdec_decode
// Combinational RV64I decode of one instruction word into kind, register
// indices, placed immediate, sign position and shift amount.
// ----------------------------------------------------------------------------
`default_nettype none

module rvdec_decode
    import rvdec_pkg::*;
(
    input  wire logic [WORD_W-1:0] word,
    output dec_res_t               res
);

    logic [6:0]   opc;
    logic [2:0]   f3;
    logic [6:0]   f7;
    logic [5:0]   f6;
    logic [4:0]   rdv;
    logic [4:0]   r1v;
    logic [4:0]   r2v;
    logic [11:0]  iimm;
    dec_res_t     raw;

    assign opc  = word[6:0];
    assign f3   = word[14:12];
    assign f7   = word[31:25];
    assign f6   = word[31:26];
    assign rdv  = word[11:7];
    assign r1v  = word[19:15];
    assign r2v  = word[24:20];
    assign iimm = word[31:20];

    always_comb
    begin
        raw = '0;
        case (opc)
            OPC_LUI, OPC_AUIPC:
            begin
                raw.valid = 1'b1;
                raw.kind  = (opc == OPC_LUI) ? K_LUI : K_AUIPC;
                raw.rd    = rdv;
                raw.imm   = {word[31:12], 12'b0};
                raw.spos  = SPOS_U;
            end
            OPC_JAL:
            begin
                raw.valid = 1'b1;
                raw.kind  = K_JAL;
                raw.rd    = rdv;
                raw.imm   = {11'b0, word[31], word[19:12], word[20], word[30:21], 1'b0};
                raw.spos  = SPOS_J;
            end
            OPC_JALR:
            begin
                raw.valid = (f3 == F3_ADD);
                raw.kind  = K_JALR;
                raw.rd    = rdv;
                raw.rs1   = r1v;
                raw.imm   = {20'b0, iimm};
                raw.spos  = SPOS_I;
            end
            OPC_BRANCH:
            begin
                raw.valid = (f3 != 3'd2) && (f3 != 3'd3);
                raw.kind  = f3[2] ? kind_t'(KIND_W'(K_BLT) + KIND_W'(f3[1:0]))
                                  : kind_t'(KIND_W'(K_BEQ) + KIND_W'(f3[0]));
                raw.rs1   = r1v;
                raw.rs2   = r2v;
                raw.imm   = {19'b0, word[31], word[7], word[30:25], word[11:8], 1'b0};
                raw.spos  = SPOS_B;
            end
            OPC_LOAD:
            begin
                raw.valid = (f3 != 3'd7);
                raw.kind  = kind_t'(KIND_W'(K_LB) + KIND_W'(f3));
                raw.rd    = rdv;
                raw.rs1   = r1v;
                raw.imm   = {20'b0, iimm};
                raw.spos  = SPOS_I;
            end
            OPC_STORE:
            begin
                raw.valid = !f3[2];
                raw.kind  = kind_t'(KIND_W'(K_SB) + KIND_W'(f3[1:0]));
                raw.rs1   = r1v;
                raw.rs2   = r2v;
                raw.imm   = {20'b0, word[31:25], word[11:7]};
                raw.spos  = SPOS_I;
            end
            OPC_OP_IMM:
            begin
                raw.rd  = rdv;
                raw.rs1 = r1v;
                if (f3 == F3_SLL || f3 == F3_SR)
                begin
                    raw.shamt = word[25:20];
                    if (f3 == F3_SLL)
                    begin
                        raw.valid = (f6 == F6_ZERO);
                        raw.kind  = K_SLLI;
                    end
                    else
                    begin
                        raw.valid = (f6 == F6_ZERO) || (f6 == F6_ALT);
                        raw.kind  = (f6 == F6_ALT) ? K_SRAI : K_SRLI;
                    end
                end
                else
                begin
                    raw.valid = 1'b1;
                    raw.imm   = {20'b0, iimm};
                    raw.spos  = SPOS_I;
                    case (f3)
                        3'd0:    raw.kind = K_ADDI;
                        3'd2:    raw.kind = K_SLTI;
                        3'd3:    raw.kind = K_SLTIU;
                        3'd4:    raw.kind = K_XORI;
                        3'd6:    raw.kind = K_ORI;
                        default: raw.kind = K_ANDI;
                    endcase
                end
            end
            OPC_OP:
            begin
                raw.rd  = rdv;
                raw.rs1 = r1v;
                raw.rs2 = r2v;
                if (f7 == F7_ZERO)
                begin
                    raw.valid = 1'b1;
                    raw.kind  = kind_t'(KIND_W'(K_ADD) + KIND_W'(f3));
                end
                else
                begin
                    raw.valid = (f7 == F7_ALT) && (f3 == F3_ADD || f3 == F3_SR);
                    raw.kind  = (f3 == F3_ADD) ? K_SUB : K_SRA;
                end
            end
            OPC_MISC_MEM:
            begin
                raw.valid = (f3 == F3_ADD);
                raw.kind  = K_FENCE;
                raw.rd    = rdv;
                raw.rs1   = r1v;
                raw.imm   = {20'b0, iimm};
                raw.spos  = SPOS_I;
            end
            OPC_SYSTEM:
            begin
                raw.valid = (f3 == F3_ADD) && (rdv == '0) && (r1v == '0)
                            && (iimm == F12_ECALL || iimm == F12_EBREAK);
                raw.kind  = (iimm == F12_EBREAK) ? K_EBREAK : K_ECALL;
            end
            OPC_OP_IMM_32:
            begin
                raw.rd  = rdv;
                raw.rs1 = r1v;
                if (f3 == F3_ADD)
                begin
                    raw.valid = 1'b1;
                    raw.kind  = K_ADDIW;
                    raw.imm   = {20'b0, iimm};
                    raw.spos  = SPOS_I;
                end
                else
                begin
                    raw.shamt = {1'b0, r2v};
                    if (f3 == F3_SLL)
                    begin
                        raw.valid = (f7 == F7_ZERO);
                        raw.kind  = K_SLLIW;
                    end
                    else
                    begin
                        raw.valid = (f3 == F3_SR) && (f7 == F7_ZERO || f7 == F7_ALT);
                        raw.kind  = (f7 == F7_ALT) ? K_SRAIW : K_SRLIW;
                    end
                end
            end
            OPC_OP_32:
            begin
                raw.rd  = rdv;
                raw.rs1 = r1v;
                raw.rs2 = r2v;
                case (f3)
                    F3_ADD:
                    begin
                        raw.valid = (f7 == F7_ZERO) || (f7 == F7_ALT);
                        raw.kind  = (f7 == F7_ALT) ? K_SUBW : K_ADDW;
                    end
                    F3_SLL:
                    begin
                        raw.valid = (f7 == F7_ZERO);
                        raw.kind  = K_SLLW;
                    end
                    F3_SR:
                    begin
                        raw.valid = (f7 == F7_ZERO) || (f7 == F7_ALT);
                        raw.kind  = (f7 == F7_ALT) ? K_SRAW : K_SRLW;
                    end
                    default:
                    begin
                        raw.valid = 1'b0;
                    end
                endcase
            end
            default:
            begin
                raw = '0;
            end
        endcase
    end

    // illegal encodings report all-zero fields
    assign res = raw.valid ? raw : '0;

endmodule

`default_nettype wire

[hw/rtl/rv64i_instruction_decoder_core.sv]
// Path: the request word is captured in the input register on acceptance, decoded
//   combinationally, and the decode is then captured in the result register.
// Throughput: one request per cycle; a new word is taken while a finished
//   result waits, and the pipe only stalls when both registers are full.
// Reset: rst_n asynchronous, clears both stage valid flags; payload is not reset.
// ----------------------------------------------------------------------------
// rv64i_instruction_decoder_core
// Two-register RV64I decoder pipeline with valid/ready on both sides.
// ----------------------------------------------------------------------------
`default_nettype none

module rv64i_instruction_decoder_core
    import rvdec_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,

    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic [WORD_W-1:0]   instr_word,

    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic                     valid_res,
    output logic [KIND_W-1:0]        op_kind,
    output logic [REG_W-1:0]         dest_reg,
    output logic [REG_W-1:0]         src_reg_a,
    output logic [REG_W-1:0]         src_reg_b,
    output logic [WORD_W-1:0]        imm_bits,
    output logic [SPOS_W-1:0]        imm_sign_pos,
    output logic [SHAMT_W-1:0]       shift_amount
);

    logic              s1_valid_reg;
    logic [WORD_W-1:0] s1_word_reg;
    logic              out_valid_reg;
    dec_res_t          res_reg;
    dec_res_t          res_next;
    logic              s1_advance;

    assign s1_advance = !out_valid_reg || out_ready;
    assign in_ready   = !s1_valid_reg || s1_advance;

    rvdec_decode u_decode (
        .word (s1_word_reg),
        .res  (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s1_advance)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            s1_word_reg <= instr_word;
        end
        if (s1_advance && s1_valid_reg)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign valid_res    = res_reg.valid;
    assign op_kind      = KIND_W'(res_reg.kind);
    assign dest_reg     = res_reg.rd;
    assign src_reg_a    = res_reg.rs1;
    assign src_reg_b    = res_reg.rs2;
    assign imm_bits     = res_reg.imm;
    assign imm_sign_pos = res_reg.spos;
    assign shift_amount = res_reg.shamt;

endmodule

`default_nettype wire

[hw/rtl/rvdec_checker.sv]
// ----------------------------------------------------------------------------
// rvdec_checker
// Port-level checks for the RV64I decoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rvdec_checker
    import rvdec_pkg::*;
(
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                out_valid,
    input wire logic                out_ready,
    input wire logic                valid_res,
    input wire logic [KIND_W-1:0]   op_kind,
    input wire logic [REG_W-1:0]    dest_reg,
    input wire logic [REG_W-1:0]    src_reg_a,
    input wire logic [REG_W-1:0]    src_reg_b,
    input wire logic [WORD_W-1:0]   imm_bits,
    input wire logic [SPOS_W-1:0]   imm_sign_pos,
    input wire logic [SHAMT_W-1:0]  shift_amount
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(op_kind) && $stable(imm_bits)
                                    && $stable(valid_res))
        else $error("stalled result changed");

    a_illegal_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !valid_res |-> op_kind == '0 && dest_reg == '0 && src_reg_a == '0
            && src_reg_b == '0 && imm_bits == '0 && imm_sign_pos == '0
            && shift_amount == '0)
        else $error("illegal encoding with nonzero fields");

    a_shamt_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && shift_amount != '0 |-> op_kind == KIND_W'(K_SLLI)
            || op_kind == KIND_W'(K_SRLI) || op_kind == KIND_W'(K_SRAI)
            || op_kind == KIND_W'(K_SLLIW) || op_kind == KIND_W'(K_SRLIW)
            || op_kind == KIND_W'(K_SRAIW))
        else $error("shift amount on a non-shift kind");

    a_imm_spos: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && imm_bits != '0 |-> imm_sign_pos == SPOS_I || imm_sign_pos == SPOS_B
            || imm_sign_pos == SPOS_J || imm_sign_pos == SPOS_U)
        else $error("immediate without a sign position");

endmodule

bind rv64i_instruction_decoder_core rvdec_checker u_rvdec_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .valid_res    (valid_res),
    .op_kind      (op_kind),
    .dest_reg     (dest_reg),
    .src_reg_a    (src_reg_a),
    .src_reg_b    (src_reg_b),
    .imm_bits     (imm_bits),
    .imm_sign_pos (imm_sign_pos),
    .shift_amount (shift_amount)
);

`default_nettype wire
